### src/gws_pkg.sv
// Shared constants, types and address helper for the grid word search block.
// Used by gws_search and grid_word_search_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gws_pkg;

   localparam int GRID_ROWS   = 8;
   localparam int GRID_COLS   = 8;
   localparam int MAX_PATTERN = 8;

   localparam int GRID_DEPTH = GRID_ROWS * GRID_COLS;
   localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
   localparam int LEN_W      = $clog2(MAX_PATTERN + 1);
   localparam int PAT_IW     = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   // search counters hold row, column and offset sums with headroom
   localparam int SRCH_W     = $clog2(GRID_ROWS + GRID_COLS + MAX_PATTERN + 1) + 1;

   localparam int CHAR_W     = 8;
   localparam int CELL_ROW_W = 3;
   localparam int CELL_COL_W = 3;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic {
      OP_GRID    = 1'b0,
      OP_PATTERN = 1'b1
   } op_type;

   typedef struct packed {
      logic             start;
      logic [LEN_W-1:0] len;
   } srch_ctl_type;

   typedef struct packed {
      logic done;
      logic found;
   } srch_sts_type;

   function automatic logic [GRID_AW-1:0] grid_addr(input logic [SRCH_W-1:0] row,
                                                     input logic [SRCH_W-1:0] col);
      logic [2*SRCH_W-1:0] full;
      full = {{SRCH_W{1'b0}}, row} * (2*SRCH_W)'(GRID_COLS)
             + {{SRCH_W{1'b0}}, col};
      return full[GRID_AW-1:0];
   endfunction

endpackage

`default_nettype wire

### src/gws_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gws_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/gws_search.sv
// Search sequencer: walks every row and column start position, one character
// compare at a time through the grid RAM read port. Depends on gws_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gws_search import gws_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srch_ctl_type       ctl,
   output srch_sts_type            sts,
   output logic                    rd_en,
   output logic [GRID_AW-1:0]      rd_addr,
   input  wire logic [CHAR_W-1:0]  rd_data,
   output logic [PAT_IW-1:0]       pat_idx,
   input  wire logic [CHAR_W-1:0]  pat_char
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP
   } state_type;

   state_type         state_ff, state_in;
   logic [SRCH_W-1:0] r_ff, r_in;
   logic [SRCH_W-1:0] c_ff, c_in;
   logic [SRCH_W-1:0] k_ff, k_in;
   logic [SRCH_W-1:0] n_ff, n_in;
   logic              dir_col_ff, dir_col_in;
   logic              done_ff, done_in;
   logic              found_ff, found_in;

   logic [SRCH_W-1:0] row_sum, col_sum, r_lim, c_lim, len_ext;

   assign row_sum = r_ff + (dir_col_ff ? k_ff : '0);
   assign col_sum = c_ff + (dir_col_ff ? '0 : k_ff);
   // last legal start position in the current direction
   assign c_lim   = dir_col_ff ? SRCH_W'(GRID_COLS - 1) : SRCH_W'(GRID_COLS) - n_ff;
   assign r_lim   = dir_col_ff ? SRCH_W'(GRID_ROWS) - n_ff : SRCH_W'(GRID_ROWS - 1);
   assign len_ext = SRCH_W'(ctl.len);

   assign rd_addr = grid_addr(row_sum, col_sum);
   assign pat_idx = k_ff[PAT_IW-1:0];

   always_comb begin
      state_in   = state_ff;
      r_in       = r_ff;
      c_in       = c_ff;
      k_in       = k_ff;
      n_in       = n_ff;
      dir_col_in = dir_col_ff;
      done_in    = 1'b0;
      found_in   = found_ff;
      rd_en      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               n_in = len_ext;
               r_in = '0;
               c_in = '0;
               k_in = '0;
               priority if (len_ext <= SRCH_W'(GRID_COLS)) begin
                  dir_col_in = 1'b0;
                  state_in   = ST_READ;
               end else if (len_ext <= SRCH_W'(GRID_ROWS)) begin
                  dir_col_in = 1'b1;
                  state_in   = ST_READ;
               end else begin
                  done_in  = 1'b1;
                  found_in = 1'b0;
               end
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            priority if (rd_data == pat_char && k_ff == n_ff - 1'b1) begin
               done_in  = 1'b1;
               found_in = 1'b1;
               state_in = ST_IDLE;
            end else if (rd_data == pat_char) begin
               k_in     = k_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               k_in     = '0;
               state_in = ST_READ;
               priority if (c_ff < c_lim) begin
                  c_in = c_ff + 1'b1;
               end else if (r_ff < r_lim) begin
                  r_in = r_ff + 1'b1;
                  c_in = '0;
               end else if (!dir_col_ff && n_ff <= SRCH_W'(GRID_ROWS)) begin
                  dir_col_in = 1'b1;
                  r_in       = '0;
                  c_in       = '0;
               end else begin
                  done_in  = 1'b1;
                  found_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      r_ff       <= r_in;
      c_ff       <= c_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      dir_col_ff <= dir_col_in;
      found_ff   <= found_in;
   end

   assign sts.done  = done_ff;
   assign sts.found = found_ff;

endmodule

`default_nettype wire

### src/grid_word_search_core.sv
// Grid word search top level: grid RAM, pattern buffer, search sequencer, two result registers.
// Grid and non-final pattern items start no search; a final pattern item that fits starts a search
// that does each character compare as a read state and a compare state through the single grid
// RAM read port; an overflowed pattern is answered at once, with no search.
// Results land in a result register; input stalls while a search runs or the spare slot is full.
// Reset clears pattern length, overflow flag and handshake state; grid contents are kept.
`timescale 1ns / 1ps
`default_nettype none

module grid_word_search_core import gws_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [2:0] cell_row, [5:3] cell_col, [13:6] char_code, [15:14] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [0] found, [1] pattern_too_long, [7:2] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  accept;
   logic [CELL_ROW_W-1:0] req_row;
   logic [CELL_COL_W-1:0] req_col;
   logic [CHAR_W-1:0]     req_char;
   logic                  is_pattern;

   logic [LEN_W-1:0]  len_ff, len_in, len_new;
   logic              ovf_ff, ovf_in, ovf_new;
   logic              busy_ff, busy_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic              rsp_long_ff, rsp_long_in;
   logic              spare_valid_ff, spare_valid_in;
   logic              spare_found_ff, spare_found_in;
   logic              spare_long_ff, spare_long_in;
   logic              res_new, res_found, res_long;
   logic [CHAR_W-1:0] pat_ff [MAX_PATTERN];
   logic              len_room;

   logic               wr_en;
   logic [GRID_AW-1:0] wr_addr;
   logic               rd_en;
   logic [GRID_AW-1:0] rd_addr;
   logic [CHAR_W-1:0]  rd_data;
   logic [PAT_IW-1:0]  pat_idx;
   srch_ctl_type       ctl;
   srch_sts_type       sts;

   assign req_row    = req_tdata[CELL_ROW_W-1:0];
   assign req_col    = req_tdata[CELL_ROW_W+CELL_COL_W-1:CELL_ROW_W];
   assign req_char   = req_tdata[CELL_ROW_W+CELL_COL_W+CHAR_W-1:CELL_ROW_W+CELL_COL_W];
   assign is_pattern = (req_tuser == OP_PATTERN);

   // a free spare slot always has room for the next result
   assign req_tready = !busy_ff && !spare_valid_ff;
   assign accept     = req_tvalid && req_tready;

   assign len_room = (len_ff < LEN_W'(MAX_PATTERN));
   assign len_new  = len_room ? len_ff + 1'b1 : len_ff;
   assign ovf_new  = ovf_ff || !len_room;

   assign wr_en   = accept && !is_pattern && (int'(req_row) < GRID_ROWS)
                    && (int'(req_col) < GRID_COLS);
   assign wr_addr = grid_addr(SRCH_W'(req_row), SRCH_W'(req_col));

   assign ctl.start = accept && is_pattern && req_tlast && !ovf_new;
   assign ctl.len   = len_new;

   always_comb begin
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      busy_in   = busy_ff;
      res_new   = 1'b0;
      res_found = 1'b0;
      res_long  = 1'b0;
      if (sts.done) begin
         busy_in   = 1'b0;
         res_new   = 1'b1;
         res_found = sts.found;
      end
      if (accept && is_pattern) begin
         if (req_tlast) begin
            len_in = '0;
            ovf_in = 1'b0;
            if (ovf_new) begin
               // overflowed pattern: answer at once, no search
               res_new  = 1'b1;
               res_long = 1'b1;
            end else begin
               busy_in = 1'b1;
            end
         end else begin
            len_in = len_new;
            ovf_in = ovf_new;
         end
      end

      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_long_in    = rsp_long_ff;
      spare_valid_in = spare_valid_ff;
      spare_found_in = spare_found_ff;
      spare_long_in  = spare_long_ff;
      // spare moves up as soon as the output register frees
      if (spare_valid_ff && !rsp_tvalid_in) begin
         rsp_tvalid_in  = 1'b1;
         rsp_found_in   = spare_found_ff;
         rsp_long_in    = spare_long_ff;
         spare_valid_in = 1'b0;
      end
      if (res_new) begin
         if (rsp_tvalid_in) begin
            spare_valid_in = 1'b1;
            spare_found_in = res_found;
            spare_long_in  = res_long;
         end else begin
            rsp_tvalid_in = 1'b1;
            rsp_found_in  = res_found;
            rsp_long_in   = res_long;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff         <= '0;
         ovf_ff         <= 1'b0;
         busy_ff        <= 1'b0;
         rsp_tvalid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         len_ff         <= len_in;
         ovf_ff         <= ovf_in;
         busy_ff        <= busy_in;
         rsp_tvalid_ff  <= rsp_tvalid_in;
         spare_valid_ff <= spare_valid_in;
      end
      rsp_found_ff   <= rsp_found_in;
      rsp_long_ff    <= rsp_long_in;
      spare_found_ff <= spare_found_in;
      spare_long_ff  <= spare_long_in;
      if (accept && is_pattern && len_room) begin
         pat_ff[len_ff[PAT_IW-1:0]] <= req_char;
      end
   end

   gws_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_char),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   gws_search u_search (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .sts      (sts),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .pat_idx  (pat_idx),
      .pat_char (pat_ff[pat_idx])
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-2){1'b0}}, rsp_long_ff, rsp_found_ff};

   // a search only finishes while one is running
   a_done_busy : assert property (@(posedge clock) disable iff (reset)
      sts.done |-> busy_ff)
      else $error("search done without a running search");

   // grid is never rewritten under a running search
   a_no_write_busy : assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff)
      else $error("grid write during search");

   // overflowed pattern never reports a match
   a_long_not_found : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> !(rsp_long_ff && rsp_found_ff))
      else $error("found and pattern_too_long both set");

   // a search start leaves the block busy with an empty pattern
   a_start_idle : assert property (@(posedge clock) disable iff (reset)
      ctl.start |=> busy_ff && len_ff == '0)
      else $error("search start did not clear the pattern");

   // a new result never lands on a full spare slot
   a_spare_free : assert property (@(posedge clock) disable iff (reset)
      res_new |-> !spare_valid_ff)
      else $error("result overwrote the spare slot");

endmodule

`default_nettype wire
